FILE: hw/rtl/swmc_pkg.sv
// Shared constants and types for the sliding-window median cost block.
package swmc_pkg;

	localparam int WINDOW_MAX_DEF  = 64;
	localparam int SAMPLE_BITS_DEF = 16;
	localparam int COST_BITS       = 22;
	localparam int COST_TDATA_W    = ((COST_BITS + 7) / 8) * 8;
	localparam int CFG_BITS        = 7;
	localparam int WINDOW_LEN_RST  = 3;
	localparam int FIFO_DEPTH      = 8;

	// Flags each cell publishes to its neighbours and to the top level.
	typedef struct packed {
		logic less;  // holds a sample below the incoming one
		logic del;   // sits at or above the sample leaving the window
		logic old;   // holds the sample leaving the window
	} cell_flags_t;

	typedef enum logic {
		PH_IDLE,
		PH_UPD
	} phase_t;

endpackage

FILE: hw/rtl/swmc_cell.sv
// One cell of the sorted window: holds a sample and its age, shifts with its neighbours.
module swmc_cell #(
	parameter int SAMPLE_BITS = swmc_pkg::SAMPLE_BITS_DEF,
	parameter int IDX_W       = 6
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     upd,
	input  logic                     clr,
	input  logic [SAMPLE_BITS-1:0]   new_val,
	input  logic [SAMPLE_BITS-1:0]   v_old,
	input  logic [IDX_W-1:0]         len_m1,
	input  logic                     full,
	input  logic [SAMPLE_BITS-1:0]   med,
	input  logic                     lo_valid,
	input  logic [SAMPLE_BITS-1:0]   lo_val,
	input  logic [IDX_W-1:0]         lo_age,
	input  swmc_pkg::cell_flags_t    lo_flags,
	input  logic                     hi_valid,
	input  logic [SAMPLE_BITS-1:0]   hi_val,
	input  logic [IDX_W-1:0]         hi_age,
	input  swmc_pkg::cell_flags_t    hi_flags,
	output logic                     valid,
	output logic [SAMPLE_BITS-1:0]   val,
	output logic [IDX_W-1:0]         age,
	output swmc_pkg::cell_flags_t    flags,
	output logic [SAMPLE_BITS-1:0]   dev
);
	import swmc_pkg::*;

	logic                   valid_q;
	logic [SAMPLE_BITS-1:0] val_q;
	logic [IDX_W-1:0]       age_q;
	logic                   is_old;
	logic                   less;
	logic                   del;
	logic                   r_less;
	logic                   rm1_less;
	logic                   nxt_valid;
	logic [SAMPLE_BITS-1:0] nxt_val;
	logic [IDX_W-1:0]       nxt_age;

	// Order is by value, then by age, so the incoming sample goes below equal values.
	assign is_old = full & valid_q & (age_q == len_m1);
	assign less   = valid_q & (val_q < new_val);
	assign del    = full & valid_q & ((val_q > v_old) | is_old);
	assign flags  = '{less: less, del: del, old: is_old};

	// After removal the survivors form a list R; these are R[i] < new and R[i-1] < new.
	assign r_less   = del ? hi_flags.less : less;
	assign rm1_less = lo_flags.del ? less : lo_flags.less;

	always_comb begin
		if (r_less) begin
			if (del) begin
				nxt_valid = hi_valid;
				nxt_val   = hi_val;
				nxt_age   = hi_age + IDX_W'(1);
			end else begin
				nxt_valid = valid_q;
				nxt_val   = val_q;
				nxt_age   = age_q + IDX_W'(1);
			end
		end else if (rm1_less) begin
			nxt_valid = 1'b1;
			nxt_val   = new_val;
			nxt_age   = '0;
		end else if (lo_flags.del) begin
			nxt_valid = valid_q;
			nxt_val   = val_q;
			nxt_age   = age_q + IDX_W'(1);
		end else begin
			nxt_valid = lo_valid;
			nxt_val   = lo_val;
			nxt_age   = lo_age + IDX_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (clr) begin
			valid_q <= 1'b0;
		end else if (upd) begin
			valid_q <= nxt_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (upd) begin
			val_q <= nxt_val;
			age_q <= nxt_age;
		end
	end

	always_comb begin
		if (!valid_q) begin
			dev = '0;
		end else if (val_q >= med) begin
			dev = val_q - med;
		end else begin
			dev = med - val_q;
		end
	end

	assign valid = valid_q;
	assign val   = val_q;
	assign age   = age_q;

endmodule

FILE: hw/rtl/swmc_add_tree.sv
// Pipelined adder tree summing the per-cell deviations, one level per stage.
module swmc_add_tree #(
	parameter int N_IN  = swmc_pkg::WINDOW_MAX_DEF,
	parameter int IN_W  = swmc_pkg::SAMPLE_BITS_DEF,
	parameter int SUM_W = swmc_pkg::COST_BITS
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic [IN_W-1:0]  dev [N_IN],
	output logic             out_valid,
	output logic [SUM_W-1:0] sum
);
	import swmc_pkg::*;

	localparam int LVLS   = (N_IN > 1) ? $clog2(N_IN) : 0;
	localparam int TREE_N = 1 << LVLS;
	localparam int VLD_W  = LVLS + 1;

	logic [SUM_W-1:0] devp  [TREE_N];
	logic [SUM_W-1:0] lvl_q [LVLS+1][TREE_N];
	logic [LVLS:0]    vld_q;

	for (genvar i = 0; i < TREE_N; i++) begin : g_pad
		if (i < N_IN) begin : g_used
			logic [IN_W+SUM_W-1:0] wide;
			assign wide    = {{SUM_W{1'b0}}, dev[i]};
			assign devp[i] = wide[SUM_W-1:0];
		end else begin : g_zero
			assign devp[i] = '0;
		end
	end

	// Sums wrap at SUM_W bits, which gives the result modulo 2^SUM_W.
	always_ff @(posedge clk) begin
		for (int i = 0; i < TREE_N; i++) begin
			lvl_q[0][i] <= devp[i];
		end
		for (int l = 1; l <= LVLS; l++) begin
			for (int i = 0; i < (TREE_N >> l); i++) begin
				lvl_q[l][i] <= lvl_q[l-1][2*i] + lvl_q[l-1][2*i+1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= VLD_W'({vld_q, in_valid});
		end
	end

	assign out_valid = vld_q[LVLS];
	assign sum       = lvl_q[LVLS][0];

endmodule

FILE: hw/rtl/sliding_window_median_cost.sv
// Top level of the sliding-window sum of absolute deviations from the lower median.
//
// Samples arrive as beats on the s_ group; cost results leave as beats on the m_ group.
// The window length is written through cfg_we/cfg_wdata; the user must write it only
// while the block is idle, which the block itself does not enforce. A length of 0 acts
// as 1 and a length above WINDOW_MAX acts as WINDOW_MAX. Every write empties the
// window, so the next window_len samples refill it before a result appears.
// Once the window is full, each sample gives one beat: the sum over the window of
// |sample - lower median|, reduced modulo 2^22.
// A sample is accepted in the idle phase; then, in the update phase, the row of
// sorted cells drops the oldest sample and inserts the new one together, and no new
// sample is taken. The path from an accepted sample to m_tvalid runs through the
// registered cell update, median select, deviation register, the adder tree levels and
// the output queue write. After reset the window is empty and window_len is 3.
// Results wait in an 8-entry output queue while m_tready is low; s_tready drops
// once 8 results are outstanding, so nothing is lost under any stall pattern.
module sliding_window_median_cost #(
	parameter int WINDOW_MAX  = swmc_pkg::WINDOW_MAX_DEF,
	parameter int SAMPLE_BITS = swmc_pkg::SAMPLE_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [swmc_pkg::CFG_BITS-1:0]       cfg_wdata,    // window_len
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [((SAMPLE_BITS+7)/8)*8-1:0]    s_tdata,      // sample
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [swmc_pkg::COST_TDATA_W-1:0]   m_tdata       // cost
);
	import swmc_pkg::*;

	localparam int IDX_W  = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
	localparam int LEN_W  = $clog2(WINDOW_MAX + 1);
	localparam int PEND_W = $clog2(FIFO_DEPTH + 1);
	localparam int FPTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;

	function automatic logic [LEN_W-1:0] eff_len(input logic [CFG_BITS-1:0] raw);
		logic [LEN_W-1:0] res;
		if (raw == '0) begin
			res = LEN_W'(1);
		end else if (int'(raw) > WINDOW_MAX) begin
			res = LEN_W'(WINDOW_MAX);
		end else begin
			res = LEN_W'(raw);
		end
		return res;
	endfunction

	phase_t                 phase_q;
	phase_t                 phase_nxt;
	logic                   accept;
	logic                   upd;
	logic [LEN_W-1:0]       len_q;
	logic [LEN_W-1:0]       count_q;
	logic [LEN_W-1:0]       len_m1_full;
	logic [IDX_W-1:0]       len_m1;
	logic [IDX_W-1:0]       mid;
	logic                   full;
	logic                   emit;
	logic [SAMPLE_BITS-1:0] s_q;
	logic [SAMPLE_BITS-1:0] v_old_q;
	logic [SAMPLE_BITS-1:0] v_old_c;
	logic [SAMPLE_BITS-1:0] med_c;
	logic                   emit_s1;
	logic [SAMPLE_BITS-1:0] med_s2;
	logic                   vld_s2;
	logic [PEND_W-1:0]      pend_q;
	logic                   out_hs;

	logic                   cell_valid [WINDOW_MAX];
	logic [SAMPLE_BITS-1:0] cell_val   [WINDOW_MAX];
	logic [IDX_W-1:0]       cell_age   [WINDOW_MAX];
	cell_flags_t            cell_flags [WINDOW_MAX];
	logic [SAMPLE_BITS-1:0] cell_dev   [WINDOW_MAX];

	logic                   tree_valid;
	logic [COST_BITS-1:0]   tree_sum;

	logic [COST_BITS-1:0]   fifo_q [FIFO_DEPTH];
	logic [FPTR_W-1:0]      wr_ptr_q;
	logic [FPTR_W-1:0]      rd_ptr_q;
	logic [PEND_W-1:0]      fcnt_q;

	assign len_m1_full = len_q - LEN_W'(1);
	assign len_m1      = len_m1_full[IDX_W-1:0];
	assign mid         = len_m1 >> 1;
	assign full        = (count_q == len_q);
	assign emit        = full || ((count_q + LEN_W'(1)) == len_q);
	assign out_hs      = m_tvalid && m_tready;

	// Control sequencer: accept a sample in PH_IDLE, then update the cells in PH_UPD.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
		end else begin
			phase_q <= phase_nxt;
		end
	end

	always_comb begin
		phase_nxt = phase_q;
		s_tready  = 1'b0;
		upd       = 1'b0;
		unique case (phase_q)
			PH_IDLE: begin
				s_tready = (pend_q < PEND_W'(FIFO_DEPTH));
				if (s_tvalid && s_tready) begin
					phase_nxt = PH_UPD;
				end
			end
			PH_UPD: begin
				upd       = 1'b1;
				phase_nxt = PH_IDLE;
			end
			default: begin
				phase_nxt = PH_IDLE;
			end
		endcase
	end

	assign accept = s_tvalid && s_tready;

	// The leaving sample is the one whose age has reached len - 1.
	always_comb begin
		v_old_c = '0;
		med_c   = '0;
		for (int i = 0; i < WINDOW_MAX; i++) begin
			v_old_c = v_old_c | (cell_val[i] & {SAMPLE_BITS{cell_flags[i].old}});
			med_c   = med_c | (cell_val[i] & {SAMPLE_BITS{IDX_W'(i) == mid}});
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			s_q     <= s_tdata[SAMPLE_BITS-1:0];
			v_old_q <= v_old_c;
		end
		med_s2 <= med_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q   <= eff_len(CFG_BITS'(WINDOW_LEN_RST));
			count_q <= '0;
			emit_s1 <= 1'b0;
			vld_s2  <= 1'b0;
			pend_q  <= '0;
		end else begin
			if (cfg_we) begin
				len_q   <= eff_len(cfg_wdata);
				count_q <= '0;
			end else if (upd && !full) begin
				count_q <= count_q + LEN_W'(1);
			end
			emit_s1 <= upd && emit;
			vld_s2  <= emit_s1;
			case ({upd && emit, out_hs})
				2'b10:   pend_q <= pend_q + PEND_W'(1);
				2'b01:   pend_q <= pend_q - PEND_W'(1);
				default: pend_q <= pend_q;
			endcase
		end
	end

	for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
		logic                   lo_valid;
		logic [SAMPLE_BITS-1:0] lo_val;
		logic [IDX_W-1:0]       lo_age;
		cell_flags_t            lo_flags;
		logic                   hi_valid;
		logic [SAMPLE_BITS-1:0] hi_val;
		logic [IDX_W-1:0]       hi_age;
		cell_flags_t            hi_flags;

		// Below the first cell sits an imaginary sample smaller than anything.
		if (i == 0) begin : g_lo_edge
			assign lo_valid = 1'b0;
			assign lo_val   = '0;
			assign lo_age   = '0;
			assign lo_flags = '{less: 1'b1, del: 1'b0, old: 1'b0};
		end else begin : g_lo
			assign lo_valid = cell_valid[i-1];
			assign lo_val   = cell_val[i-1];
			assign lo_age   = cell_age[i-1];
			assign lo_flags = cell_flags[i-1];
		end

		if (i == WINDOW_MAX - 1) begin : g_hi_edge
			assign hi_valid = 1'b0;
			assign hi_val   = '0;
			assign hi_age   = '0;
			assign hi_flags = '{less: 1'b0, del: 1'b0, old: 1'b0};
		end else begin : g_hi
			assign hi_valid = cell_valid[i+1];
			assign hi_val   = cell_val[i+1];
			assign hi_age   = cell_age[i+1];
			assign hi_flags = cell_flags[i+1];
		end

		swmc_cell #(
			.SAMPLE_BITS (SAMPLE_BITS),
			.IDX_W       (IDX_W)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.upd      (upd),
			.clr      (cfg_we),
			.new_val  (s_q),
			.v_old    (v_old_q),
			.len_m1   (len_m1),
			.full     (full),
			.med      (med_s2),
			.lo_valid (lo_valid),
			.lo_val   (lo_val),
			.lo_age   (lo_age),
			.lo_flags (lo_flags),
			.hi_valid (hi_valid),
			.hi_val   (hi_val),
			.hi_age   (hi_age),
			.hi_flags (hi_flags),
			.valid    (cell_valid[i]),
			.val      (cell_val[i]),
			.age      (cell_age[i]),
			.flags    (cell_flags[i]),
			.dev      (cell_dev[i])
		);
	end

	swmc_add_tree #(
		.N_IN  (WINDOW_MAX),
		.IN_W  (SAMPLE_BITS),
		.SUM_W (COST_BITS)
	) u_tree (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_s2),
		.dev       (cell_dev),
		.out_valid (tree_valid),
		.sum       (tree_sum)
	);

	// Output queue; the outstanding count at the input keeps it from overflowing.
	always_ff @(posedge clk) begin
		if (tree_valid) begin
			fifo_q[wr_ptr_q] <= tree_sum;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fcnt_q   <= '0;
		end else begin
			if (tree_valid) begin
				wr_ptr_q <= wr_ptr_q + FPTR_W'(1);
			end
			if (out_hs) begin
				rd_ptr_q <= rd_ptr_q + FPTR_W'(1);
			end
			case ({tree_valid, out_hs})
				2'b10:   fcnt_q <= fcnt_q + PEND_W'(1);
				2'b01:   fcnt_q <= fcnt_q - PEND_W'(1);
				default: fcnt_q <= fcnt_q;
			endcase
		end
	end

	assign m_tvalid = (fcnt_q != '0);
	assign m_tdata  = {{(COST_TDATA_W - COST_BITS){1'b0}}, fifo_q[rd_ptr_q]};

endmodule
